// ===== hdl/oaid_pkg.sv =====
package oaid_pkg;

  // Operation codes carried in the mode field of a command word
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } oaid_mode_e;

  // Completion codes carried in the status field of a result word
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_BAD_INDEX = 2'd3
  } oaid_status_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 5;
  localparam int unsigned CountW = 6;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
  } oaid_cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [CountW-1:0]       entry_count;
    logic signed [DataW-1:0] read_data;
  } oaid_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the command word and register the match vector
    logic exec;   // apply the update and register the result word
  } oaid_ctrl_t;

endpackage

// ===== hdl/oaid_ctrl.sv =====
module oaid_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output oaid_pkg::oaid_ctrl_t ctrl_o
);
  import oaid_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } oaid_state_e;

  oaid_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    ctrl_o.load = 1'b0;
    ctrl_o.exec = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/oaid_datapath.sv =====
module oaid_datapath #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  oaid_pkg::oaid_ctrl_t ctrl_i,
  input  oaid_pkg::oaid_cmd_t  cmd_i,
  output oaid_pkg::oaid_rsp_t  rsp_o,
  output logic                 done_o
);
  import oaid_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  logic signed [DataW-1:0] entries_q [CAPACITY];
  logic signed [DataW-1:0] entries_d [CAPACITY];
  logic [CntW-1:0]         count_q, count_d;
  oaid_cmd_t               cmd_q;
  logic [CAPACITY-1:0]     match_q, match_d;
  oaid_rsp_t               rsp_q;
  logic                    done_q;

  logic [IdxW-1:0]         pos_idx;
  logic [CmpW-1:0]         pos_ext, cnt_ext;
  logic                    full, found;
  logic [CAPACITY-1:0]     lt_mask, ge_mask;
  logic [1:0]              status;
  logic signed [DataW-1:0] rdata;

  // Compare every live entry against the incoming value
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      match_d[k] = (entries_q[k] == cmd_i.value) && (CntW'(k) < count_q);
    end
  end

  assign pos_idx = IdxW'(cmd_q.position);
  assign pos_ext = CmpW'(cmd_q.position);
  assign cnt_ext = CmpW'(count_q);
  assign full    = (count_q == CntW'(CAPACITY));
  assign found   = |match_q;
  // Bits below the first match, and from the first match upward
  assign lt_mask = (match_q ^ (match_q - CAPACITY'(1))) >> 1;
  assign ge_mask = ~lt_mask;

  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    status    = STAT_OK;
    rdata     = '0;
    unique case (cmd_q.mode)
      MODE_INSERT: begin
        if (full) begin
          status = STAT_FULL;
        end else if (pos_ext > cnt_ext) begin
          status = STAT_BAD_INDEX;
        end else begin
          for (int k = 1; k < CAPACITY; k++) begin
            if (IdxW'(k) > pos_idx) begin
              entries_d[k] = entries_q[k-1];
            end
          end
          entries_d[pos_idx] = cmd_q.value;
          count_d            = count_q + CntW'(1);
        end
      end
      MODE_DELETE: begin
        if (!found) begin
          status = STAT_NOT_FOUND;
        end else begin
          for (int k = 0; k < CAPACITY - 1; k++) begin
            if (ge_mask[k]) begin
              entries_d[k] = entries_q[k+1];
            end
          end
          count_d = count_q - CntW'(1);
        end
      end
      MODE_READ: begin
        if (pos_ext >= cnt_ext) begin
          status = STAT_BAD_INDEX;
        end else begin
          rdata = entries_q[pos_idx];
        end
      end
      default: begin
        status = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_i;
      match_q <= match_d;
    end
    if (ctrl_i.exec) begin
      entries_q         <= entries_d;
      rsp_q.status      <= status;
      rsp_q.entry_count <= CountW'(count_d);
      rsp_q.read_data   <= rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ctrl_i.exec;
      if (ctrl_i.exec) begin
        count_q <= count_d;
      end
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

// ===== hdl/ordered_array_insert_delete_core.sv =====
// Packed list of up to CAPACITY signed 32-bit entries with insert at an index, delete of the
// first matching value and read at an index. A command word is taken at a clock edge where
// start_i is high and busy_o is low; busy_o then stays high for one cycle. The load step
// registers an equality compare of every live entry, and the exec step applies the parallel
// shift up or down and registers the result word. That word is held on result_o until the
// next command completes; done_o is high for exactly one cycle as busy_o falls, so the next
// command may be started in that same cycle; the receiver cannot stall and must take the
// word when done_o is high. Status reports ok, full, value not found or index out of range;
// entry_count is the count after the command, kept to six bits. Entries are not cleared by
// reset, but only positions below the count are ever looked at.
module ordered_array_insert_delete_core #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  oaid_pkg::oaid_cmd_t cmd_i,
  output logic                busy_o,
  output logic                done_o,
  output oaid_pkg::oaid_rsp_t result_o
);
  import oaid_pkg::*;

  // Commands from the sequencer to the datapath
  oaid_ctrl_t ctrl;

  // Sequence each command word through compare and update
  oaid_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .ctrl_o  (ctrl)
  );

  // Hold the entries and the count, and form the result word
  oaid_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cmd_i  (cmd_i),
    .rsp_o  (result_o),
    .done_o (done_o)
  );

endmodule
